/* hw/rtl/beg_pkg.sv */
`timescale 1ns / 1ps
package beg_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned FracBits  = 24;
  localparam int unsigned AccW      = 41;
  localparam int unsigned StepW     = 42;
  localparam int unsigned LenW      = 32;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_FAST    = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;
  localparam logic [2:0] CMD_WRITE   = 3'd5;

  localparam logic [1:0] CFG_TIME_SCALE = 2'd0;
  localparam logic [1:0] CFG_SUSTAIN    = 2'd1;
  localparam logic [1:0] CFG_COUNT      = 2'd2;
  localparam logic [1:0] CFG_FAST_LEN   = 2'd3;

  typedef struct packed {
    logic       exec;
    logic       seg_start;
    logic       fast_start;
    logic       div_step;
    logic       finish;
  } beg_cmd_t;

  typedef struct packed {
    logic       need_seg;
    logic       need_fast;
  } beg_sts_t;
endpackage

/* hw/rtl/beg_ctrl.sv */
`timescale 1ns / 1ps
module beg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  beg_pkg::beg_sts_t sts,
  output logic              in_ready,
  output beg_pkg::beg_cmd_t cmd
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_seg) state_nxt = ST_MUL;
        else if (sts.need_fast) begin
          cmd.fast_start = 1'b1;
          cnt_nxt = 6'd0;
          state_nxt = ST_DIV;
        end else state_nxt = ST_DONE;
      end
      ST_MUL: begin
        cmd.seg_start = 1'b1;
        cnt_nxt = 6'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd40) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

/* hw/rtl/beg_dp.sv */
`timescale 1ns / 1ps
module beg_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [2:0]        in_command,
  input  logic [3:0]        in_point_index,
  input  logic [15:0]       in_point_time,
  input  logic [15:0]       in_point_level,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_data,
  input  beg_pkg::beg_cmd_t cmd,
  output beg_pkg::beg_sts_t sts,
  output logic [15:0]       res_level,
  output logic              res_playing,
  output logic              res_holding
);
  localparam int unsigned AW = beg_pkg::AccW;
  localparam int unsigned SW = beg_pkg::StepW;
  localparam int unsigned LW = beg_pkg::LenW;

  logic [31:0] time_scale_r;
  logic [4:0]  sustain_r, count_r;
  logic [15:0] fast_len_r;

  logic [15:0] bp_time_mem [beg_pkg::MaxPoints];
  logic [15:0] bp_level_mem [beg_pkg::MaxPoints];

  logic [2:0]    cmd_r;
  logic [3:0]    pidx_r;
  logic [15:0]   ptime_r, plevel_r;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [LW-1:0] el_r, el_nxt, len_r, len_nxt;
  logic [4:0]    stage_r, stage_nxt;
  logic act_r, act_nxt, rel_r, rel_nxt, fast_r, fast_nxt;
  logic [15:0]   lvl_r, lvl_nxt;
  logic          seg_nxt, fast_go_nxt;
  logic [15:0]   d_r;
  logic          neg_r;
  logic [AW-1:0] rem_r, mag_r;
  logic [AW-1:0] quo_r;
  logic [5:0]    bit_r;

  logic [4:0] eff;
  always_comb begin
    eff = count_r;
    if (eff == 5'd0) eff = 5'd1;
    if (eff > 5'(beg_pkg::MaxPoints)) eff = 5'(beg_pkg::MaxPoints);
  end

  function automatic logic [15:0] sat(input logic [AW-1:0] a);
    logic [AW-1-beg_pkg::FracBits:0] v;
    v = a[AW-1:beg_pkg::FracBits];
    return (v > 17'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  logic [AW-1:0] tgt;
  assign tgt    = {1'b0, bp_level_mem[stage_r[3:0]], 24'd0};

  logic holding;
  assign holding = act_r && !rel_r && !fast_r && stage_r == sustain_r && el_r >= len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_scale_r <= 32'd2890138;
      sustain_r    <= 5'd16;
      count_r      <= 5'd1;
      fast_len_r   <= 16'd132;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        beg_pkg::CFG_TIME_SCALE: time_scale_r <= cfg_data;
        beg_pkg::CFG_SUSTAIN:    sustain_r    <= cfg_data[4:0];
        beg_pkg::CFG_COUNT:      count_r      <= cfg_data[4:0];
        beg_pkg::CFG_FAST_LEN:   fast_len_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command; pidx_r <= in_point_index;
      ptime_r <= in_point_time; plevel_r <= in_point_level;
    end
    if (cmd.exec && cmd_r == beg_pkg::CMD_WRITE) begin
      bp_time_mem[pidx_r]  <= ptime_r;
      bp_level_mem[pidx_r] <= plevel_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r; step_nxt = step_r; el_nxt = el_r; len_nxt = len_r;
    stage_nxt = stage_r; act_nxt = act_r; rel_nxt = rel_r; fast_nxt = fast_r;
    lvl_nxt = 16'd0; seg_nxt = 1'b0; fast_go_nxt = 1'b0;
    unique case (cmd_r)
      beg_pkg::CMD_TICK: begin
        if (!act_r) fast_nxt = 1'b0;
        else if (fast_r) begin
          if (el_r >= len_r) begin
            acc_nxt = '0; act_nxt = 1'b0; rel_nxt = 1'b0; fast_nxt = 1'b0;
          end else begin
            acc_nxt = acc_r + AW'(step_r); el_nxt = el_r + LW'(1);
          end
        end else if (el_r >= len_r) begin
          acc_nxt = tgt;
          if (!(!rel_r && stage_r == sustain_r)) begin
            if (stage_r + 5'd1 >= eff) begin
              act_nxt = 1'b0; rel_nxt = 1'b0; fast_nxt = 1'b0;
            end else begin
              stage_nxt = stage_r + 5'd1; seg_nxt = 1'b1;
            end
          end
        end else begin
          acc_nxt = acc_r + AW'(step_r); el_nxt = el_r + LW'(1);
        end
      end
      beg_pkg::CMD_START: begin
        act_nxt = 1'b1; rel_nxt = 1'b0; fast_nxt = 1'b0;
        acc_nxt = '0; stage_nxt = 5'd0; seg_nxt = 1'b1;
      end
      beg_pkg::CMD_RELEASE: begin
        if (act_r && !fast_r) begin
          rel_nxt = 1'b1;
          if (holding) begin
            if (stage_r + 5'd1 < eff) begin
              stage_nxt = stage_r + 5'd1; seg_nxt = 1'b1;
            end
          end else begin
            stage_nxt = eff - 5'd1; seg_nxt = 1'b1;
          end
        end
      end
      beg_pkg::CMD_FAST: begin
        if (act_r) begin
          rel_nxt = 1'b1; fast_nxt = 1'b1;
          len_nxt = LW'(fast_len_r); el_nxt = '0; fast_go_nxt = 1'b1;
        end
      end
      beg_pkg::CMD_STOP: begin
        act_nxt = 1'b0; rel_nxt = 1'b0; fast_nxt = 1'b0; acc_nxt = '0;
      end
      default: ;
    endcase
    if (act_nxt || cmd_r == beg_pkg::CMD_TICK) lvl_nxt = sat(acc_nxt);
    if (!act_nxt && cmd_r != beg_pkg::CMD_TICK) lvl_nxt = 16'd0;
    if (cmd_r == beg_pkg::CMD_TICK && !act_r) lvl_nxt = 16'd0;
  end

  assign sts.need_seg  = seg_nxt;
  assign sts.need_fast = fast_go_nxt;

  logic [AW-1:0] diff_w;
  logic [47:0]   prod;
  logic [LW-1:0] seg_len;
  logic [AW:0]   trial;
  assign diff_w  = (tgt >= acc_r) ? tgt - acc_r : acc_r - tgt;
  assign prod    = d_r * time_scale_r;
  assign seg_len = prod[47:16];
  assign trial   = {1'b0, rem_r[AW-2:0], mag_r[AW-1]} - {{(AW+1-LW){1'b0}}, len_r};

  logic [AW-1:0] acc_fin;
  logic          first_step, hold_fin;
  assign acc_fin    = acc_r + (neg_r ? AW'(-quo_r) : quo_r);
  assign first_step = bit_r != 6'd0 && cmd_r == beg_pkg::CMD_TICK;
  assign hold_fin   = first_step ? (act_r && !rel_r && !fast_r && stage_r == sustain_r &&
                                    len_r <= LW'(1)) : holding;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; step_r <= '0; el_r <= '0; len_r <= '0; stage_r <= '0;
      act_r <= 1'b0; rel_r <= 1'b0; fast_r <= 1'b0; lvl_r <= '0;
      res_level <= '0; res_playing <= 1'b0; res_holding <= 1'b0;
      d_r <= '0; neg_r <= 1'b0; rem_r <= '0; mag_r <= '0; quo_r <= '0; bit_r <= '0;
    end else begin
      if (cmd.exec) begin
        acc_r <= acc_nxt; step_r <= step_nxt; el_r <= el_nxt; len_r <= len_nxt;
        stage_r <= stage_nxt; act_r <= act_nxt; rel_r <= rel_nxt; fast_r <= fast_nxt;
        lvl_r <= lvl_nxt;
        d_r <= (bp_time_mem[stage_nxt[3:0]] > ((stage_nxt == 5'd0) ? 16'd0 :
                bp_time_mem[4'(stage_nxt - 5'd1)])) ?
               bp_time_mem[stage_nxt[3:0]] - ((stage_nxt == 5'd0) ? 16'd0 :
                bp_time_mem[4'(stage_nxt - 5'd1)]) : 16'd0;
      end
      if (cmd.seg_start) begin
        len_r <= seg_len; el_r <= '0;
        neg_r <= tgt < acc_r; mag_r <= diff_w; rem_r <= '0; quo_r <= '0;
      end
      if (cmd.fast_start) begin
        neg_r <= 1'b1; mag_r <= acc_r; rem_r <= '0; quo_r <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[AW]) begin
          rem_r <= trial[AW-1:0]; quo_r <= {quo_r[AW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[AW-2:0], mag_r[AW-1]}; quo_r <= {quo_r[AW-2:0], 1'b0};
        end
        mag_r <= {mag_r[AW-2:0], 1'b0};
        bit_r <= bit_r + 6'd1;
      end
      if (cmd.finish) begin
        if (bit_r != 6'd0 || len_r == '0) begin
          if (len_r == '0) step_r <= '0;
          else step_r <= neg_r ? SW'(-{1'b0, quo_r}) : SW'({1'b0, quo_r});
        end
        if (first_step && len_r != '0) begin
          acc_r     <= acc_fin;
          el_r      <= 32'd1;
          res_level <= sat(acc_fin);
        end else begin
          if (first_step) el_r <= 32'd1;
          res_level <= lvl_r;
        end
        bit_r <= '0;
        res_playing <= act_r;
        res_holding <= hold_fin;
      end
    end
  end
endmodule

/* hw/rtl/breakpoint_envelope_generator_core.sv */
`timescale 1ns / 1ps
// Multi-segment linear envelope generator.
// Requests arrive on the in_ channel: a command with point index, time and level.
// Command 0 advances the envelope by one sample; 1 to 5 start, release,
// fast-release, stop or write a breakpoint; 6 and 7 do nothing. Every
// request yields exactly one result on the out_ channel: the level, playing
// and holding flags after it. Registers are written through cfg_we, cfg_addr
// and cfg_data while idle; the user must keep to this, the block does not
// enforce it. A request without a division passes the execute and done
// states; the next one can be taken only after the previous one has finished.
// A request that starts a segment needs the product of time difference and
// time scale and a 41-bit restoring division, one quotient bit per cycle,
// before its result is valid. A fast release skips the product.
// The result register holds its value while out_tready is low; meanwhile one
// further request is taken and worked on, and its result waits until the
// register is free.
// A synchronous active-low reset clears the envelope to idle and sets the
// registers to their defaults; breakpoints are undefined until written.
module breakpoint_envelope_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // command, point_index, point_time, point_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // level, playing, holding
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  beg_pkg::beg_cmd_t cmd;
  beg_pkg::beg_sts_t sts;
  logic        in_fire, ready_c;
  logic [15:0] lvl;
  logic        ply, hld;
  logic        ov_r;

  assign in_tready = ready_c;
  assign in_fire   = in_tvalid && in_tready;

  beg_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free(!ov_r || out_tready), .sts, .in_ready(ready_c), .cmd
  );

  beg_dp u_dp (
    .clk, .rst_n, .in_fire,
    .in_command(in_tdata[2:0]), .in_point_index(in_tdata[6:3]),
    .in_point_time(in_tdata[22:7]), .in_point_level(in_tdata[38:23]),
    .cfg_we, .cfg_idx(cfg_addr), .cfg_data, .cmd, .sts,
    .res_level(lvl), .res_playing(ply), .res_holding(hld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, hld, ply, lvl};

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !ov_r || out_tready) else $error("result overwritten");
  a_hold_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[16]) else $error("holding while idle");
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [15:0] level;
    logic        playing;
    logic        holding;
  } env_sample_t;

  class env_scoreboard;
    bit [31:0] time_scale;
    bit [4:0]  sustain_pt;
    bit [4:0]  num_points;
    bit [15:0] fast_len;
    bit [15:0] pt_time [16];
    bit [15:0] pt_level [16];
    longint    acc;
    longint    step;
    bit [31:0] elapsed;
    bit [31:0] seg_len;
    int unsigned stage;
    bit active, released, fast_mode;
    env_sample_t pending_samples[$];
    int errors;

    function new();
      time_scale = 32'd2890138;
      sustain_pt = 5'd16;
      num_points = 5'd1;
      fast_len = 16'd132;
      foreach (pt_time[i]) begin
        pt_time[i] = '0;
        pt_level[i] = '0;
      end
      acc = 0;
      step = 0;
      elapsed = 0;
      seg_len = 0;
      stage = 0;
      active = 0;
      released = 0;
      fast_mode = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] addr, logic [31:0] data);
      case (addr)
        beg_pkg::CFG_TIME_SCALE: time_scale = data;
        beg_pkg::CFG_SUSTAIN: sustain_pt = data[4:0];
        beg_pkg::CFG_COUNT: num_points = data[4:0];
        default: fast_len = data[15:0];
      endcase
    endfunction

    function int unsigned used_points();
      if (num_points == 0) return 1;
      if (num_points > 16) return 16;
      return num_points;
    endfunction

    function longint target(int unsigned i);
      if (i >= 16) return 0;
      return longint'(pt_level[i]) <<< 24;
    endfunction

    function longint divide_toward_zero(longint diff, bit [31:0] len);
      longint mag;
      if (len == 0) return 0;
      mag = (diff < 0) ? -diff : diff;
      mag = mag / longint'(len);
      return (diff < 0) ? -mag : mag;
    endfunction

    function void open_segment();
      longint t, p, d;
      t = (stage < 16) ? pt_time[stage] : 0;
      p = (stage > 0 && stage - 1 < 16) ? pt_time[stage-1] : 0;
      d = (t > p) ? t - p : 0;
      seg_len = 32'((d * longint'(time_scale)) >> 16);
      elapsed = 0;
      step = divide_toward_zero(target(stage) - acc, seg_len);
    endfunction

    function bit at_hold();
      return active && !released && !fast_mode && stage == sustain_pt && elapsed >= seg_len;
    endfunction

    function logic [15:0] saturate(longint a);
      longint v;
      if (a <= 0) return 0;
      v = a >>> 24;
      return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function void stop_all();
      active = 0;
      released = 0;
      fast_mode = 0;
    endfunction

    function logic [15:0] advance();
      if (!active) begin
        fast_mode = 0;
        return 0;
      end
      if (fast_mode) begin
        if (elapsed >= seg_len) begin
          acc = 0;
          stop_all();
          return 0;
        end
        acc += step;
        elapsed++;
        return saturate(acc);
      end
      if (elapsed >= seg_len) begin
        acc = target(stage);
        if (!released && stage == sustain_pt) return saturate(acc);
        if (stage + 1 >= used_points()) begin
          stop_all();
          return saturate(acc);
        end
        stage++;
        open_segment();
      end
      acc += step;
      elapsed++;
      return saturate(acc);
    endfunction

    function void note_request(logic [39:0] d);
      env_sample_t s;
      logic [2:0] cmd;
      bit ticked;
      cmd = d[2:0];
      ticked = 0;
      case (cmd)
        beg_pkg::CMD_TICK: begin
          s.level = advance();
          ticked = 1;
        end
        beg_pkg::CMD_START: begin
          stop_all();
          active = 1;
          acc = 0;
          stage = 0;
          open_segment();
        end
        beg_pkg::CMD_RELEASE: begin
          if (active && !fast_mode) begin
            if (at_hold()) begin
              released = 1;
              if (stage + 1 < used_points()) begin
                stage++;
                open_segment();
              end
            end else begin
              released = 1;
              stage = used_points() - 1;
              open_segment();
            end
          end
        end
        beg_pkg::CMD_FAST: begin
          if (active) begin
            released = 1;
            fast_mode = 1;
            seg_len = fast_len;
            elapsed = 0;
            step = divide_toward_zero(-acc, seg_len);
          end
        end
        beg_pkg::CMD_STOP: begin
          stop_all();
          acc = 0;
        end
        beg_pkg::CMD_WRITE: begin
          pt_time[d[6:3]] = d[22:7];
          pt_level[d[6:3]] = d[38:23];
        end
        default: ;
      endcase
      if (!ticked) s.level = active ? saturate(acc) : 16'd0;
      s.playing = active;
      s.holding = at_hold();
      pending_samples.push_back(s);
    endfunction

    function void check_result(logic [23:0] d);
      env_sample_t e;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (d[15:0] !== e.level || d[16] !== e.playing || d[17] !== e.holding
          || d[23:18] !== 6'd0) begin
        $display("%0t: expected level %0d playing %0b holding %0b, got %h",
                 $time, e.level, e.playing, e.holding, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data;

  env_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycles;

  breakpoint_envelope_generator_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (cycles > 2000000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(logic [2:0] cmd, logic [3:0] idx = 0,
                              logic [15:0] t = 0, logic [15:0] lvl = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, lvl, t, idx, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_point(int i, logic [15:0] t, logic [15:0] lvl);
    send_request(beg_pkg::CMD_WRITE, 4'(i), t, lvl);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_samples.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(addr, data);
    @(negedge clk);
  endtask

  task automatic ticks(int n);
    repeat (n) send_request(beg_pkg::CMD_TICK);
  endtask

  task automatic random_run(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 70) send_request(beg_pkg::CMD_TICK);
      else if (r < 76) send_request(beg_pkg::CMD_START);
      else if (r < 82) send_request(beg_pkg::CMD_RELEASE);
      else if (r < 86) send_request(beg_pkg::CMD_FAST);
      else if (r < 89) send_request(beg_pkg::CMD_STOP);
      else if (r < 92) send_request(3'($urandom_range(6, 7)), 4'($urandom),
                                    16'($urandom), 16'($urandom));
      else write_point($urandom_range(15), 16'($urandom_range(0, 12)),
                       16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // Directed part: extremes of the table and of every command.
    write_reg(beg_pkg::CFG_TIME_SCALE, 32'h0002_0000);
    write_reg(beg_pkg::CFG_COUNT, 32'd4);
    write_reg(beg_pkg::CFG_SUSTAIN, 32'd1);
    write_reg(beg_pkg::CFG_FAST_LEN, 32'd3);
    send_request(beg_pkg::CMD_TICK);
    send_request(beg_pkg::CMD_RELEASE);
    send_request(beg_pkg::CMD_FAST);
    write_point(0, 16'd2, 16'hFFFF);
    write_point(1, 16'd1, 16'd0);
    write_point(2, 16'hFFFF, 16'h8000);
    write_point(3, 16'd3, 16'd1234);
    for (int i = 4; i < 16; i++) write_point(i, 16'(i), 16'(i * 4000));
    send_request(beg_pkg::CMD_START);
    ticks(7);
    send_request(beg_pkg::CMD_RELEASE);
    ticks(2);
    send_request(beg_pkg::CMD_RELEASE);
    send_request(beg_pkg::CMD_FAST);
    ticks(5);
    send_request(3'd6);
    send_request(3'd7, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(beg_pkg::CMD_STOP);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: write_reg(beg_pkg::CFG_TIME_SCALE, 32'h0000_0000);
        1: write_reg(beg_pkg::CFG_TIME_SCALE, 32'hFFFF_FFFF);
        2: write_reg(beg_pkg::CFG_TIME_SCALE,
                     32'($urandom_range(32'h0000_4000, 32'h0003_0000)));
        default: write_reg(beg_pkg::CFG_TIME_SCALE,
                           32'($urandom_range(32'h0000_8000, 32'h0002_0000)));
      endcase
      write_reg(beg_pkg::CFG_COUNT, (ph == 1) ? 32'd31 : (ph == 0) ? 32'd0 :
                32'($urandom_range(1, 16)));
      write_reg(beg_pkg::CFG_SUSTAIN, (ph == 2) ? 32'd0 : 32'($urandom_range(0, 31)));
      write_reg(beg_pkg::CFG_FAST_LEN, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF :
                32'($urandom_range(1, 20)));
      if (ph == 1) begin
        // Long full-scale case: only a start, a few ticks and a stop.
        send_request(beg_pkg::CMD_START);
        ticks(20);
        send_request(beg_pkg::CMD_STOP);
      end else begin
        random_run(135);
      end
      if (ph == 3) begin
        drain();
        send_request(beg_pkg::CMD_TICK);
      end
      drain();
    end
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/beg_pkg.sv
hw/rtl/beg_ctrl.sv
hw/rtl/beg_dp.sv
hw/rtl/breakpoint_envelope_generator_core.sv
dv/tb.sv
